// ===== src/sbo_pkg.sv =====
// ----------------------------------------------------------------------------
// sbo_pkg: shared definitions for the swept box overlap test
// Holds the fixed Q16.16 word sizes, the saturation limits, and the command
// and status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sbo_pkg;

    localparam int Q_W   = 32;               // width of one Q-format word
    localparam int DT_W  = 31;               // width of the frame time
    localparam int CNT_W = $clog2(Q_W);      // divide step counter width

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;    // register the incoming request
        logic prep;       // classify the axis and form the divide operands
        logic div_init;   // load both dividers
        logic div_step;   // one quotient bit in both dividers
        logic fold;       // merge this axis into the running times
    } t_sbo_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;   // this axis needs the quotients
        logic last;       // this axis closes the pair test
        logic out_free;   // the result register can take a new result
    } t_sbo_stat;

endpackage

// ===== src/sbo_divider.sv =====
// ----------------------------------------------------------------------------
// sbo_divider: serial fixed-point divider with saturation
// Restoring divider that produces one quotient bit per step. The magnitude of
// the numerator is scaled by 2^FRAC_BITS, and the signed result saturates to
// the Q-format range.
// ----------------------------------------------------------------------------
module sbo_divider #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_init,
    input  logic                               i_step,
    input  logic [sbo_pkg::Q_W-1:0]            i_num_mag,
    input  logic [sbo_pkg::Q_W-1:0]            i_den_mag,
    input  logic                               i_neg,
    output logic signed [sbo_pkg::Q_W-1:0]     o_quot
);
    import sbo_pkg::*;

    localparam int SH = Q_W - FRAC_BITS;

    logic [Q_W-1:0] r_rem;
    logic [Q_W-1:0] r_q;
    logic [Q_W-1:0] r_den;
    logic           r_ovf;
    logic           r_neg;

    logic [Q_W-1:0] hi;
    logic [Q_W:0]   trial;
    logic [Q_W:0]   diff;

    // The scaled numerator is split into the part above the quotient window,
    // which seeds the remainder, and the low word shifted in bit by bit.
    assign hi    = i_num_mag >> SH;
    assign trial = {r_rem, r_q[Q_W-1]};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_rem <= hi;
            r_q   <= i_num_mag << FRAC_BITS;
            r_den <= i_den_mag;
            r_ovf <= (hi >= i_den_mag);
            r_neg <= i_neg;
        end else if (i_step) begin
            if (!diff[Q_W]) begin
                r_rem <= diff[Q_W-1:0];
                r_q   <= {r_q[Q_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[Q_W-1:0];
                r_q   <= {r_q[Q_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (r_ovf) begin
            o_quot = r_neg ? Q_MIN : Q_MAX;
        end else if (r_neg) begin
            o_quot = r_q[Q_W-1] ? Q_MIN : -r_q;
        end else begin
            o_quot = r_q[Q_W-1] ? Q_MAX : r_q;
        end
    end

endmodule

// ===== src/sbo_datapath.sv =====
// ----------------------------------------------------------------------------
// sbo_datapath: operand registers, dividers and running times
// Classifies one axis, forms the two divide operands, runs the dividers,
// folds the axis times into the running start and end, and holds the result.
// ----------------------------------------------------------------------------
module sbo_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sbo_pkg::t_sbo_cmd                  i_cmd,
    output sbo_pkg::t_sbo_stat                 o_stat,
    input  logic signed [sbo_pkg::Q_W-1:0]     i_a_min,
    input  logic signed [sbo_pkg::Q_W-1:0]     i_a_max,
    input  logic signed [sbo_pkg::Q_W-1:0]     i_b_min,
    input  logic signed [sbo_pkg::Q_W-1:0]     i_b_max,
    input  logic signed [sbo_pkg::Q_W-1:0]     i_rel_velocity,
    input  logic [sbo_pkg::DT_W-1:0]           i_delta_t,
    input  logic                               i_last_axis,
    input  logic                               i_stall,
    output logic                               o_valid,
    output logic                               o_hit,
    output logic signed [sbo_pkg::Q_W-1:0]     o_overlap_start,
    output logic signed [sbo_pkg::Q_W-1:0]     o_overlap_end
);
    import sbo_pkg::*;

    typedef enum logic [1:0] {
        CASE_MID,
        CASE_RIGHT,
        CASE_LEFT
    } t_sbo_case;

    // Captured request.
    logic signed [Q_W-1:0] r_a_min, r_a_max, r_b_min, r_b_max, r_v;
    logic [DT_W-1:0]       r_dt;
    logic                  r_last;

    // Prepared operands.
    t_sbo_case             r_case;
    logic [Q_W-1:0]        r_num_s, r_num_e, r_den;
    logic                  r_neg_s, r_neg_e;
    logic                  r_need;
    logic signed [Q_W-1:0] r_never;

    // Running times and result register.
    logic signed [Q_W-1:0] r_run_start, r_run_end;
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic signed [Q_W-1:0] r_out_start, r_out_end;

    logic signed [Q_W:0]   da, db, sel_s, sel_e;
    logic                  is_right, is_left, v_neg, v_zero;
    logic [Q_W:0]          mag_s, mag_e;
    logic [Q_W-1:0]        den_mag;
    logic [Q_W-1:0]        never_sum;
    t_sbo_case             case_now;
    logic                  need_now;
    logic signed [Q_W-1:0] quot_s, quot_e, ax_s, ax_e, new_start, new_end;
    logic                  out_free;

    // Classification and operand selection.
    always_comb begin
        da       = {r_a_max[Q_W-1], r_a_max} - {r_b_min[Q_W-1], r_b_min};
        db       = {r_a_min[Q_W-1], r_a_min} - {r_b_max[Q_W-1], r_b_max};
        is_right = (r_b_min > r_a_max);
        is_left  = (r_b_max < r_a_min);
        v_neg    = r_v[Q_W-1];
        v_zero   = (r_v == '0);
        if (is_right) begin
            case_now = CASE_RIGHT;
            need_now = v_neg;
            sel_s    = da;
            sel_e    = db;
        end else if (is_left) begin
            case_now = CASE_LEFT;
            need_now = !v_neg && !v_zero;
            sel_s    = db;
            sel_e    = da;
        end else begin
            case_now = CASE_MID;
            need_now = !v_zero;
            sel_s    = db;
            sel_e    = v_neg ? db : da;
        end
        mag_s     = sel_s[Q_W] ? -sel_s : sel_s;
        mag_e     = sel_e[Q_W] ? -sel_e : sel_e;
        den_mag   = v_neg ? -r_v : r_v;
        never_sum = {1'b0, r_dt} + (Q_W'(1) << FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_a_min <= i_a_min;
            r_a_max <= i_a_max;
            r_b_min <= i_b_min;
            r_b_max <= i_b_max;
            r_v     <= i_rel_velocity;
            r_dt    <= i_delta_t;
            r_last  <= i_last_axis;
        end
        if (i_cmd.prep) begin
            r_case  <= case_now;
            r_need  <= need_now;
            r_num_s <= mag_s[Q_W-1:0];
            r_num_e <= mag_e[Q_W-1:0];
            r_neg_s <= sel_s[Q_W] ^ v_neg;
            r_neg_e <= sel_e[Q_W] ^ v_neg;
            r_den   <= den_mag;
            r_never <= never_sum[Q_W-1] ? Q_MAX : never_sum;
        end
    end

    sbo_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_start (
        .i_clk     (i_clk),
        .i_init    (i_cmd.div_init),
        .i_step    (i_cmd.div_step),
        .i_num_mag (r_num_s),
        .i_den_mag (r_den),
        .i_neg     (r_neg_s),
        .o_quot    (quot_s)
    );

    sbo_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div_end (
        .i_clk     (i_clk),
        .i_init    (i_cmd.div_init),
        .i_step    (i_cmd.div_step),
        .i_num_mag (r_num_e),
        .i_den_mag (r_den),
        .i_neg     (r_neg_e),
        .o_quot    (quot_e)
    );

    // Axis times and the merge into the running window.
    always_comb begin
        ax_e = r_need ? quot_e : r_never;
        if (r_case == CASE_MID) begin
            ax_s = '0;
        end else begin
            ax_s = r_need ? quot_s : r_never;
        end
        new_start = (ax_s > r_run_start) ? ax_s : r_run_start;
        new_end   = (ax_e < r_run_end) ? ax_e : r_run_end;
        out_free  = !r_out_valid || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_start <= Q_MIN;
            r_run_end   <= Q_MAX;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.fold) begin
                if (r_last) begin
                    r_run_start <= Q_MIN;
                    r_run_end   <= Q_MAX;
                    r_out_valid <= 1'b1;
                end else begin
                    r_run_start <= new_start;
                    r_run_end   <= new_end;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fold && r_last) begin
            r_out_start <= new_start;
            r_out_end   <= new_end;
            r_out_hit   <= (new_start < $signed({1'b0, r_dt})) && (new_end > 0);
        end
    end

    assign o_stat.need_div = r_need;
    assign o_stat.last     = r_last;
    assign o_stat.out_free = out_free;

    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_overlap_start = r_out_start;
    assign o_overlap_end   = r_out_end;

    a_result_follows_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fold && r_last) |=> r_out_valid)
        else $error("closing axis did not post a result");

    a_window_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fold && r_last) |=> (r_run_start == Q_MIN && r_run_end == Q_MAX))
        else $error("running window not cleared after the closing axis");

endmodule

// ===== src/sbo_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbo_ctrl: sequencing for the swept box overlap test
// Steps one request through capture, operand setup, the serial divide (when
// needed) and the merge; a last-axis merge waits while the held result is stalled.
// ----------------------------------------------------------------------------
module sbo_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  sbo_pkg::t_sbo_stat i_stat,
    output logic               o_stall,
    output sbo_pkg::t_sbo_cmd  o_cmd
);
    import sbo_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_INIT = 5'b00100,
        S_DIV  = 5'b01000,
        S_FOLD = 5'b10000
    } t_sbo_state;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_W - 1);

    t_sbo_state       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_INIT;
            end
            S_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = i_stat.need_div ? S_DIV : S_FOLD;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_FOLD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FOLD: begin
                if (!i_stat.last || i_stat.out_free) begin
                    o_cmd.fold = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    a_close_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.fold && i_stat.last) |-> i_stat.out_free)
        else $error("result posted while the result register was occupied");

    a_divide_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == CNT_LAST) |=> (r_state == S_FOLD))
        else $error("divide did not end after the full quotient");

    a_init_step_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.div_init && o_cmd.div_step))
        else $error("divider loaded and stepped in the same cycle");

endmodule

// ===== src/swept_box_overlap_test_core.sv =====
// ----------------------------------------------------------------------------
// swept_box_overlap_test_core: swept axis-aligned box overlap test
// Takes one axis of a two-box test per request, computes when the boxes
// start and stop overlapping on that axis, and keeps the tightest window.
// The request marked as the last axis produces the hit decision.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  input     in         i_valid / o_stall    a_min, a_max, b_min, b_max,
//                                            rel_velocity, delta_t, last_axis
//  result    out        o_valid / i_stall    hit, overlap_start, overlap_end
//
// A request that needs the quotients passes from acceptance to the next
// acceptance through capture, operand setup, divider load, 32 divide steps that
// each produce one quotient bit in both serial dividers, and the merge.
// A request whose axis needs no division skips the divide steps.
// The synchronous active-low reset clears the sequencer, the result valid and
// the running window (start at the most negative value, end at the most
// positive). A result waits in its own register; the next request is still
// taken, and only the merge of a last axis holds while it is full and stalled.
// ----------------------------------------------------------------------------
module swept_box_overlap_test_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Request channel.
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [sbo_pkg::Q_W-1:0]     i_a_min,
    input  logic signed [sbo_pkg::Q_W-1:0]     i_a_max,
    input  logic signed [sbo_pkg::Q_W-1:0]     i_b_min,
    input  logic signed [sbo_pkg::Q_W-1:0]     i_b_max,
    input  logic signed [sbo_pkg::Q_W-1:0]     i_rel_velocity,
    input  logic [sbo_pkg::DT_W-1:0]           i_delta_t,
    input  logic                               i_last_axis,
    // Result channel.
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_hit,
    output logic signed [sbo_pkg::Q_W-1:0]     o_overlap_start,
    output logic signed [sbo_pkg::Q_W-1:0]     o_overlap_end
);
    import sbo_pkg::*;

    // The controller and the datapath talk only through these two groups.
    t_sbo_cmd  cmd;
    t_sbo_stat stat;

    // The sequencer accepts a request only when idle and walks it through
    // setup, the divide and the merge.
    sbo_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    // The datapath holds the request, both dividers, the running window and
    // the result register that parts the result channel from the work.
    sbo_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_a_min         (i_a_min),
        .i_a_max         (i_a_max),
        .i_b_min         (i_b_min),
        .i_b_max         (i_b_max),
        .i_rel_velocity  (i_rel_velocity),
        .i_delta_t       (i_delta_t),
        .i_last_axis     (i_last_axis),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_overlap_start (o_overlap_start),
        .o_overlap_end   (o_overlap_end)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression for the swept box overlap test core
// Drives single-axis requests into the core and folds each one into a model
// of the overlap window kept here. Every result from a request marked as the
// last axis is checked field by field against the window predicted for it.
// Both channels idle at random so that gaps land on every divide phase.
// ----------------------------------------------------------------------------
module tb_top;
    import sbo_pkg::*;

    localparam int FRAC = 16;
    localparam logic [DT_W-1:0] DT_TOP = 31'h7FFE_FFFF;   // largest legal frame time
    localparam int HANG_LIMIT = 2000;                     // cycles without any handshake
    localparam int DRAIN_CYCLES = 80;                     // wait after the last window for any stray result

    // One request as it crosses the input channel.
    typedef struct {
        logic signed [Q_W-1:0] a_min;
        logic signed [Q_W-1:0] a_max;
        logic signed [Q_W-1:0] b_min;
        logic signed [Q_W-1:0] b_max;
        logic signed [Q_W-1:0] vel;
        logic [DT_W-1:0]       dt;
        logic                  last;
    } t_axis_req;

    // The window reported at the close of one pair test.
    typedef struct {
        logic                  hit;
        logic signed [Q_W-1:0] start_t;
        logic signed [Q_W-1:0] end_t;
    } t_window;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_RUNS, STALL_LIGHT} t_stall_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic signed [Q_W-1:0] i_a_min = '0;
    logic signed [Q_W-1:0] i_a_max = '0;
    logic signed [Q_W-1:0] i_b_min = '0;
    logic signed [Q_W-1:0] i_b_max = '0;
    logic signed [Q_W-1:0] i_rel_velocity = '0;
    logic [DT_W-1:0]       i_delta_t = '0;
    logic                  i_last_axis = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_hit;
    logic signed [Q_W-1:0] o_overlap_start;
    logic signed [Q_W-1:0] o_overlap_end;

    // Running window of the pair test in progress, as the core should hold it.
    logic signed [Q_W-1:0] win_start = Q_MIN;
    logic signed [Q_W-1:0] win_end = Q_MAX;
    t_window expected_windows[$];

    int mismatches = 0;
    int axes_sent = 0;
    int pairs_sent = 0;
    int windows_seen = 0;
    int hits_seen = 0;
    int burst_left = 0;
    int hang_count = 0;

    swept_box_overlap_test_core #(
        .FRAC_BITS(FRAC)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_a_min        (i_a_min),
        .i_a_max        (i_a_max),
        .i_b_min        (i_b_min),
        .i_b_max        (i_b_max),
        .i_rel_velocity (i_rel_velocity),
        .i_delta_t      (i_delta_t),
        .i_last_axis    (i_last_axis),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_hit          (o_hit),
        .o_overlap_start(o_overlap_start),
        .o_overlap_end  (o_overlap_end)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Window prediction
    // ------------------------------------------------------------------------

    // Saturates a wide intermediate to the signed Q16.16 range.
    function automatic logic signed [Q_W-1:0] clamp_q(input longint v);
        if (v > longint'(Q_MAX)) return Q_MAX;
        if (v < longint'(Q_MIN)) return Q_MIN;
        return v[Q_W-1:0];
    endfunction

    // Time for an edge gap to close: the gap is scaled up to the fixed-point
    // grid before dividing, and SystemVerilog division truncates toward zero
    // just as a sign-magnitude divider does. The divisor is never zero here.
    function automatic logic signed [Q_W-1:0] q_ratio(input longint gap, input longint vel);
        return clamp_q((gap * (longint'(1) <<< FRAC)) / vel);
    endfunction

    // Works out when this axis starts and stops overlapping, narrows the
    // running window with it, and on the last axis queues the window that the
    // core has to report before restarting from the widest window.
    function automatic void fold_axis(input t_axis_req ax);
        longint                amin, amax, bmin, bmax, vel, dt;
        logic signed [Q_W-1:0] never_t, t_in, t_out;
        t_window               w;
        amin = ax.a_min;
        amax = ax.a_max;
        bmin = ax.b_min;
        bmax = ax.b_max;
        vel = ax.vel;
        dt = ax.dt;
        // "Never" sits one time unit past the end of the frame.
        never_t = clamp_q(dt + (longint'(1) <<< FRAC));
        if (bmin > amax) begin
            // B lies to the right of A; only a B moving left can reach it.
            if (vel < 0) begin
                t_in = q_ratio(amax - bmin, vel);
                t_out = q_ratio(amin - bmax, vel);
            end else begin
                t_in = never_t;
                t_out = never_t;
            end
        end else if (bmax < amin) begin
            // B lies to the left of A. A partial overlap can never also pass
            // this test, so checking it after the right case keeps the order.
            if (vel > 0) begin
                t_in = q_ratio(amin - bmax, vel);
                t_out = q_ratio(amax - bmin, vel);
            end else begin
                t_in = never_t;
                t_out = never_t;
            end
        end else begin
            // Partial overlap, containment either way, touching edges and
            // malformed boxes all count as overlapping from time zero.
            t_in = '0;
            if (vel < 0) begin
                t_out = q_ratio(amin - bmax, vel);
            end else if (vel > 0) begin
                t_out = q_ratio(amax - bmin, vel);
            end else begin
                t_out = never_t;
            end
        end
        if (t_in > win_start) win_start = t_in;
        if (t_out < win_end) win_end = t_out;
        if (ax.last) begin
            w.hit = (longint'(win_start) < dt) && (win_end > 0);
            w.start_t = win_start;
            w.end_t = win_end;
            expected_windows.push_back(w);
            win_start = Q_MIN;
            win_end = Q_MAX;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Whole Q16.16 units, for readable directed values.
    function automatic logic signed [Q_W-1:0] fx(input int units);
        return units * (1 << FRAC);
    endfunction

    function automatic t_axis_req mk_axis(input logic signed [Q_W-1:0] a_lo, a_hi, b_lo, b_hi,
                                          input logic signed [Q_W-1:0] vel,
                                          input logic [DT_W-1:0] frame, input logic last);
        t_axis_req ax;
        ax.a_min = a_lo;
        ax.a_max = a_hi;
        ax.b_min = b_lo;
        ax.b_max = b_hi;
        ax.vel = vel;
        ax.dt = frame;
        ax.last = last;
        return ax;
    endfunction

    // Sends one request. The sender works in bursts: when a burst runs out it
    // may drop valid for a random gap before the next one starts. The task is
    // entered and left at a rising edge, and valid stays high on return so a
    // following request in the same burst goes out back to back.
    task automatic send_axis(input t_axis_req ax);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
                // A long stretch without any idling.
                burst_left = $urandom_range(20, 60);
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 8);
                gap = $urandom_range(0, 45);
            end
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_a_min <= ax.a_min;
        i_a_max <= ax.a_max;
        i_b_min <= ax.b_min;
        i_b_max <= ax.b_max;
        i_rel_velocity <= ax.vel;
        i_delta_t <= ax.dt;
        i_last_axis <= ax.last;
        do @(posedge i_clk); while (o_stall);
        fold_axis(ax);
        axes_sent++;
        if (ax.last) pairs_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: checking and stall pattern
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        $display("MISMATCH at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    endtask

    // Every result taken is matched with the oldest predicted window. The
    // stall pattern changes mode at random: no stall at all, a coin flip per
    // cycle, long stalled runs with short openings, or light stalling.
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          run_left = 0;
    logic        run_hold = 1'b0;

    always @(posedge i_clk) begin
        t_window w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_windows.size() == 0) begin
                flag_mismatch("result with no pair test closed", 0, 1);
            end else begin
                w = expected_windows.pop_front();
                windows_seen++;
                if (o_hit === 1'b1) hits_seen++;
                if (o_hit !== w.hit) flag_mismatch("hit", w.hit, o_hit);
                if (o_overlap_start !== w.start_t)
                    flag_mismatch("overlap_start", w.start_t, o_overlap_start);
                if (o_overlap_end !== w.end_t)
                    flag_mismatch("overlap_end", w.end_t, o_overlap_end);
            end
        end
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(64, 600);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE: begin
                i_stall <= 1'b0;
            end
            STALL_COIN: begin
                i_stall <= ($urandom_range(0, 1) == 1);
            end
            STALL_RUNS: begin
                if (run_left == 0) begin
                    run_hold = !run_hold;
                    run_left = run_hold ? $urandom_range(1, 50) : $urandom_range(1, 6);
                end
                run_left--;
                i_stall <= run_hold;
            end
            default: begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    // The run is declared hung when neither channel completes a handshake for
    // far longer than the slowest request, the longest sender gap and the
    // longest receiver stall put together.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            hang_count = 0;
        end else begin
            hang_count++;
        end
        if (hang_count >= HANG_LIMIT) begin
            $display("Hang: no handshake for %0d cycles, %0d windows still pending.",
                     HANG_LIMIT, expected_windows.size());
            $display("swept_box_overlap_test_core regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // One single-axis pair test for each way B can sit against A, each with
    // the velocity signs that matter for it.
    task automatic test_axis_cases();
        // B to the right and closing in: window from 0.5 to 1.5.
        send_axis(mk_axis(fx(0), fx(2), fx(4), fx(6), -fx(4), fx(1), 1'b1));
        // B to the right, moving away or standing still: never overlaps.
        send_axis(mk_axis(fx(0), fx(2), fx(4), fx(6), fx(1), fx(1), 1'b1));
        send_axis(mk_axis(fx(0), fx(2), fx(4), fx(6), fx(0), fx(1), 1'b1));
        // B to the left, closing in and moving away.
        send_axis(mk_axis(fx(0), fx(2), -fx(5), -fx(3), fx(2), fx(2), 1'b1));
        send_axis(mk_axis(fx(0), fx(2), -fx(5), -fx(3), -fx(1), fx(2), 1'b1));
        // Partial overlap from above and from below, and standing still.
        send_axis(mk_axis(fx(0), fx(4), fx(2), fx(6), -fx(2), fx(1), 1'b1));
        send_axis(mk_axis(fx(0), fx(4), -fx(2), fx(2), fx(3), fx(1), 1'b1));
        send_axis(mk_axis(fx(0), fx(4), -fx(2), fx(2), fx(0), fx(1), 1'b1));
        // B inside A, then A inside B.
        send_axis(mk_axis(fx(0), fx(8), fx(2), fx(3), fx(1), fx(1), 1'b1));
        send_axis(mk_axis(fx(2), fx(3), fx(0), fx(8), -fx(1), fx(1), 1'b1));
        // Edges exactly touching.
        send_axis(mk_axis(fx(0), fx(2), fx(2), fx(4), fx(0), fx(1), 1'b1));
        // Box A given with its edges swapped; the end time comes out negative.
        send_axis(mk_axis(fx(5), fx(1), fx(2), fx(3), -fx(1), fx(1), 1'b1));
    endtask

    // Extreme edges and velocities: quotients that saturate both ways, the
    // smallest and largest velocity magnitudes, and both frame time limits.
    task automatic test_field_extremes();
        send_axis(mk_axis(Q_MIN, Q_MIN, Q_MAX, Q_MAX, -32'sd1, '0, 1'b1));
        send_axis(mk_axis(Q_MAX, Q_MAX, Q_MIN, Q_MIN, 32'sd1, DT_TOP, 1'b1));
        send_axis(mk_axis(Q_MAX, Q_MIN, Q_MIN + 1, Q_MIN + 1, -32'sd1, DT_TOP, 1'b1));
        send_axis(mk_axis(Q_MIN, Q_MAX, fx(0), fx(0), Q_MIN, fx(1), 1'b1));
        // A frame of zero length: a start at zero is not inside it.
        send_axis(mk_axis(fx(0), fx(1), -fx(1), 32'sd1, Q_MAX, '0, 1'b1));
    endtask

    // Pair tests over several axes, so the window narrows from both sides.
    task automatic test_multi_axis();
        // Three axes that overlap from 0.5 to 1.5 inside a frame of one unit.
        send_axis(mk_axis(fx(0), fx(2), fx(4), fx(6), -fx(4), fx(1), 1'b0));
        send_axis(mk_axis(fx(0), fx(4), fx(2), fx(6), -fx(2), fx(1), 1'b0));
        send_axis(mk_axis(fx(0), fx(8), fx(2), fx(3), fx(0), fx(1), 1'b1));
        // Four axes whose window opens only after the frame has ended.
        send_axis(mk_axis(fx(0), fx(2), -fx(5), -fx(3), fx(2), fx(1), 1'b0));
        send_axis(mk_axis(fx(0), fx(2), fx(4), fx(6), -fx(4), fx(1), 1'b0));
        send_axis(mk_axis(fx(2), fx(3), fx(0), fx(8), fx(0), fx(1), 1'b0));
        send_axis(mk_axis(fx(0), fx(4), -fx(2), fx(2), fx(3), fx(1), 1'b1));
    endtask

    // Random pair tests of one to four axes, now and then more, that share a
    // frame time. Most axes are well-formed boxes at one of three scales so
    // that hits and misses both occur; about one in ten is pure noise with a
    // last flag of its own, which can cut a test short.
    task automatic test_random_pairs(input int n_items);
        t_axis_req       ax;
        logic [DT_W-1:0] frame;
        int              sent, axes, lim, v;
        sent = 0;
        while (sent < n_items) begin
            axes = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 4);
            case ($urandom_range(0, 7))
                0: frame = '0;
                1: frame = DT_TOP;
                2: frame = DT_W'($urandom_range(0, DT_TOP));
                default: frame = DT_W'($urandom_range(1, 4 << FRAC));
            endcase
            for (int k = 0; k < axes; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    ax.a_min = $urandom;
                    ax.a_max = $urandom;
                    ax.b_min = $urandom;
                    ax.b_max = $urandom;
                    ax.vel = $urandom;
                    ax.dt = DT_W'($urandom_range(0, DT_TOP));
                    ax.last = ($urandom_range(0, 1) == 1);
                end else begin
                    case ($urandom_range(0, 3))
                        0, 1: lim = 18;
                        2: lim = 22;
                        default: lim = 29;
                    endcase
                    ax.a_min = int'($urandom_range(0, 2 << lim)) - (1 << lim);
                    ax.a_max = ax.a_min + int'($urandom_range(0, 1 << (lim - 2)));
                    ax.b_min = int'($urandom_range(0, 2 << lim)) - (1 << lim);
                    // Now and then make the edges touch.
                    if ($urandom_range(0, 15) == 0) ax.b_min = ax.a_max;
                    ax.b_max = ax.b_min + int'($urandom_range(0, 1 << (lim - 2)));
                    if ($urandom_range(0, 15) == 0) ax.b_max = ax.a_min;
                    case ($urandom_range(0, 7))
                        0: v = 0;
                        1: v = $urandom_range(0, 1) ? 1 : -1;
                        2: v = $urandom;
                        3: v = $urandom_range(0, 1) ? fx(1) : -fx(1);
                        default: v = int'($urandom_range(0, 2 << lim)) - (1 << lim);
                    endcase
                    ax.vel = v;
                    ax.dt = frame;
                    ax.last = (k == axes - 1);
                end
                send_axis(ax);
            end
            sent += axes;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_axis_cases();
        test_field_extremes();
        test_multi_axis();
        test_random_pairs(1026);
        i_valid <= 1'b0;
        // Let the last windows come out, then give the core time to show any
        // result that nothing asked for. The hang watchdog bounds the wait.
        while (expected_windows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_windows.size() != 0)
            flag_mismatch("windows never reported", 0, expected_windows.size());
        $display("Sent %0d axis requests closing %0d pair tests; checked %0d windows.",
                 axes_sent, pairs_sent, windows_seen);
        $display("%0d windows reported a hit; %0d mismatches.", hits_seen, mismatches);
        if (mismatches == 0) begin
            $display("swept_box_overlap_test_core regression: pass");
        end else begin
            $display("swept_box_overlap_test_core regression: fail");
        end
        $finish;
    end

endmodule
